// File: design/bmg_pkg.sv
// shared types and constants of the gaussian pair unit
package bmg_pkg;

  localparam int LOG_STEPS = 28;
  localparam int LW = 34;
  localparam int SW = 36;
  localparam int XW = 38;
  localparam int RW = 19;
  localparam int TW = 30;
  localparam int HORNER_LAT = 3;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [29:0] LN2X2_Q29 = 30'd744261118;
  localparam logic [30:0] TWOPI_Q28 = 31'd1686629713;

  typedef enum logic [0:0] {
    REG_MEAN_VALUE = 1'b0,
    REG_STD_DEV    = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic [15:0] uniform_radius;
    logic [15:0] uniform_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] first_normal;
    logic signed [23:0] second_normal;
  } out_item_t;

  typedef struct packed {
    logic [31:0] m;
    logic [LOG_STEPS-1:0] f;
    logic [4:0] e;
    logic zero;
  } log_st_t;

  typedef struct packed {
    logic [XW-1:0] rem;
    logic [RW-1:0] res;
  } sqrt_st_t;

endpackage

// File: design/bmg_log_cell.sv
// one squaring step of the base-two logarithm
module bmg_log_cell import bmg_pkg::*; #(
  parameter int BIT_POS = 0
) (
  input  logic    clk,
  input  log_st_t st_in,
  output log_st_t st_out
);

  log_st_t st_r, st_nxt;
  logic [63:0] sq;
  logic [32:0] sh;

  always_comb begin
    sq = 64'(st_in.m) * 64'(st_in.m);
    sh = sq[63:31];
    st_nxt = st_in;
    if (sh[32]) begin
      st_nxt.m = sh[32:1];
      st_nxt.f[BIT_POS] = 1'b1;
    end else begin
      st_nxt.m = sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign st_out = st_r;

endmodule

// File: design/bmg_sqrt_cell.sv
// one result bit of the integer square root
module bmg_sqrt_cell import bmg_pkg::*; #(
  parameter int K = 0
) (
  input  logic     clk,
  input  sqrt_st_t st_in,
  output sqrt_st_t st_out
);

  sqrt_st_t st_r, st_nxt;
  logic [XW+1:0] trial;

  always_comb begin
    trial = ((XW+2)'(st_in.res) << (K + 1)) + ((XW+2)'(1) << (2 * K));
    st_nxt = st_in;
    if ({2'b00, st_in.rem} >= trial) begin
      st_nxt.rem = st_in.rem - trial[XW-1:0];
      st_nxt.res[K] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign st_out = st_r;

endmodule

// File: design/bmg_horner_cell.sv
// one horner step of the sine and cosine series
module bmg_horner_cell import bmg_pkg::*; #(
  parameter int DIV = 6,
  parameter bit USE_T = 1'b0
) (
  input  logic          clk,
  input  logic [TW-1:0] x_in,
  input  logic [TW-1:0] t_in,
  input  logic [TW-1:0] t2_in,
  output logic [TW-1:0] y_out,
  output logic [TW-1:0] t_out,
  output logic [TW-1:0] t2_out
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);

  logic [TW-1:0] qa_r, qa_nxt, xa_r, ta_r, t2a_r;
  logic [30:0]   yb_r, yb_nxt;
  logic [TW-1:0] tb_r, t2b_r;
  logic [TW-1:0] yc_r, yc_nxt, tc_r, t2c_r;
  logic [63:0]   qprod;
  logic [33:0]   rem;
  logic [TW-1:0] qfix;
  logic [TW-1:0] op;
  logic [61:0]   prod;

  always_comb begin
    qprod = 64'(x_in) * 64'(RECIP);
    qa_nxt = qprod[61:32];
  end

  // reciprocal estimate is at most one low
  always_comb begin
    rem = 34'(xa_r) - 34'(qa_r) * 34'(DIV);
    qfix = (rem >= 34'(DIV)) ? TW'(qa_r + 1'b1) : qa_r;
    yb_nxt = Q30_ONE - 31'(qfix);
  end

  always_comb begin
    op = USE_T ? tb_r : t2b_r;
    prod = 62'(op) * 62'(yb_r);
    yc_nxt = prod[59:30];
  end

  always_ff @(posedge clk) begin
    qa_r  <= qa_nxt;
    xa_r  <= x_in;
    ta_r  <= t_in;
    t2a_r <= t2_in;
    yb_r  <= yb_nxt;
    tb_r  <= ta_r;
    t2b_r <= t2a_r;
    yc_r  <= yc_nxt;
    tc_r  <= tb_r;
    t2c_r <= t2b_r;
  end

  assign y_out  = yc_r;
  assign t_out  = tc_r;
  assign t2_out = t2c_r;

endmodule

// File: design/box_muller_gaussian_pair_unit.sv
// box-muller gaussian pair unit, top level
// throughput: one pair per cycle, busy stays low, results cannot be held off
// the radius path runs through 28 logarithm squaring cells and 19 square root cells in a row
// reset: pipeline valid bits cleared, mean_value to 0, std_dev to 1.0
module box_muller_gaussian_pair_unit import bmg_pkg::*; #(
  parameter int UNIFORM_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_data,
  output logic       out_valid,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int R_STAGE = 1 + LOG_STEPS + 2 + RW;
  localparam int TRIG_STAGE = 3 + 3 * HORNER_LAT + 1;
  localparam int DLY = R_STAGE - TRIG_STAGE;
  localparam int OUT_STAGE = R_STAGE + 3;
  localparam logic [15:0] IN_MASK =
    (UNIFORM_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << UNIFORM_BITS) - 1);

  logic acc;
  logic [OUT_STAGE:0] vld_r, vld_nxt;
  logic signed [15:0] mean_r;
  logic [15:0] std_r;

  assign busy = 1'b0;
  assign acc = start && !busy;
  assign vld_nxt = {vld_r[OUT_STAGE-1:0], acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      mean_r <= '0;
      std_r  <= 16'd256;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_we && cfg_index == REG_MEAN_VALUE) begin
        mean_r <= $signed(cfg_wdata);
      end
      if (cfg_we && cfg_index == REG_STD_DEV) begin
        std_r <= cfg_wdata;
      end
    end
  end

  // input stage
  logic [15:0] u1_r, u2_r;

  always_ff @(posedge clk) begin
    u1_r <= in_data.uniform_radius & IN_MASK;
    u2_r <= in_data.uniform_angle & IN_MASK;
  end

  // radius path
  log_st_t log_in_nxt;
  log_st_t log_st [0:LOG_STEPS];
  logic [4:0] lead;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 16; i++) begin
      if (u1_r[i]) begin
        lead = 5'(i);
      end
    end
    log_in_nxt.e = lead;
    log_in_nxt.zero = (u1_r == 16'd0);
    log_in_nxt.f = '0;
    log_in_nxt.m = 32'(u1_r) << (5'd31 - lead);
  end

  log_st_t log_in_r;

  always_ff @(posedge clk) begin
    log_in_r <= log_in_nxt;
  end

  assign log_st[0] = log_in_r;

  for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
    bmg_log_cell #(.BIT_POS(LOG_STEPS - 1 - i)) u_cell (
      .clk    (clk),
      .st_in  (log_st[i]),
      .st_out (log_st[i+1])
    );
  end

  logic [LW-1:0] lval_r, lval_nxt;
  logic [63:0]   sprod;
  sqrt_st_t      sq_in_r, sq_in_nxt;
  sqrt_st_t      sq_st [0:RW];

  always_comb begin
    if (log_st[LOG_STEPS].zero) begin
      lval_nxt = '0;
    end else begin
      lval_nxt = (LW'(UNIFORM_BITS) << 28)
               - ((LW'(log_st[LOG_STEPS].e) << 28) + LW'(log_st[LOG_STEPS].f));
    end
    sprod = 64'(lval_r) * 64'(LN2X2_Q29);
    sq_in_nxt.rem = {sprod[SW+26:27], 2'b00};
    sq_in_nxt.res = '0;
  end

  always_ff @(posedge clk) begin
    lval_r  <= lval_nxt;
    sq_in_r <= sq_in_nxt;
  end

  assign sq_st[0] = sq_in_r;

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    bmg_sqrt_cell #(.K(RW - 1 - j)) u_cell (
      .clk    (clk),
      .st_in  (sq_st[j]),
      .st_out (sq_st[j+1])
    );
  end

  logic [RW-1:0] rad;
  assign rad = sq_st[RW].res;

  // angle path
  logic [31:0] phase, dlt;
  logic [1:0]  quad;
  logic [29:0] dabs_r;
  logic        dneg_r;
  logic [1:0]  q1_r;
  logic [63:0] tprod;
  logic [TW-1:0] t_r, t3_r, t2_3_r;
  logic [1:0]  q2_r, q3_r;
  logic        dneg2_r, dneg3_r;
  logic [59:0] t2prod;

  always_comb begin
    phase = 32'(u2_r) << (32 - UNIFORM_BITS);
    quad = 2'((phase + 32'h2000_0000) >> 30);
    dlt = phase - {quad, 30'd0};
    tprod = 64'(dabs_r) * 64'(TWOPI_Q28);
    t2prod = 60'(t_r) * 60'(t_r);
  end

  always_ff @(posedge clk) begin
    q1_r    <= quad;
    dneg_r  <= dlt[31];
    dabs_r  <= dlt[31] ? 30'(32'(0) - dlt) : dlt[29:0];
    t_r     <= tprod[59:30];
    q2_r    <= q1_r;
    dneg2_r <= dneg_r;
    t3_r    <= t_r;
    t2_3_r  <= t2prod[59:30];
    q3_r    <= q2_r;
    dneg3_r <= dneg2_r;
  end

  logic [TW-1:0] sy [0:3];
  logic [TW-1:0] st_t [0:3];
  logic [TW-1:0] st_t2 [0:3];
  logic [TW-1:0] cy [0:3];
  logic [TW-1:0] ct_t [0:3];
  logic [TW-1:0] ct_t2 [0:3];

  assign sy[0] = t2_3_r;
  assign st_t[0] = t3_r;
  assign st_t2[0] = t2_3_r;
  assign cy[0] = t2_3_r;
  assign ct_t[0] = t3_r;
  assign ct_t2[0] = t2_3_r;

  localparam int SIN_DIV [0:2] = '{42, 20, 6};
  localparam int COS_DIV [0:2] = '{56, 30, 12};

  for (genvar k = 0; k < 3; k++) begin : g_horner
    bmg_horner_cell #(.DIV(SIN_DIV[k]), .USE_T(k == 2)) u_sin (
      .clk    (clk),
      .x_in   (sy[k]),
      .t_in   (st_t[k]),
      .t2_in  (st_t2[k]),
      .y_out  (sy[k+1]),
      .t_out  (st_t[k+1]),
      .t2_out (st_t2[k+1])
    );
    bmg_horner_cell #(.DIV(COS_DIV[k]), .USE_T(1'b0)) u_cos (
      .clk    (clk),
      .x_in   (cy[k]),
      .t_in   (ct_t[k]),
      .t2_in  (ct_t2[k]),
      .y_out  (cy[k+1]),
      .t_out  (ct_t[k+1]),
      .t2_out (ct_t2[k+1])
    );
  end

  localparam int SIDE_DLY = 3 * HORNER_LAT;
  logic [1:0] qd_r [0:SIDE_DLY-1];
  logic       nd_r [0:SIDE_DLY-1];

  always_ff @(posedge clk) begin
    qd_r[0] <= q3_r;
    nd_r[0] <= dneg3_r;
    for (int i = 1; i < SIDE_DLY; i++) begin
      qd_r[i] <= qd_r[i-1];
      nd_r[i] <= nd_r[i-1];
    end
  end

  logic [30:0]        cosv;
  logic signed [31:0] cv, sv, xc_nxt, xs_nxt;

  always_comb begin
    cosv = Q30_ONE - 31'(cy[3] >> 1);
    cv = $signed({1'b0, cosv});
    sv = $signed({2'b00, sy[3]});
    if (nd_r[SIDE_DLY-1]) begin
      sv = -sv;
    end
    unique case (quad_t'(qd_r[SIDE_DLY-1]))
      QUAD_0: begin
        xc_nxt = cv;
        xs_nxt = sv;
      end
      QUAD_1: begin
        xc_nxt = -sv;
        xs_nxt = cv;
      end
      QUAD_2: begin
        xc_nxt = -cv;
        xs_nxt = -sv;
      end
      QUAD_3: begin
        xc_nxt = sv;
        xs_nxt = -cv;
      end
      default: begin
        xc_nxt = cv;
        xs_nxt = sv;
      end
    endcase
  end

  // align the trig values with the radius
  logic signed [31:0] xc_d [0:DLY];
  logic signed [31:0] xs_d [0:DLY];

  always_ff @(posedge clk) begin
    xc_d[0] <= xc_nxt;
    xs_d[0] <= xs_nxt;
    for (int i = 1; i <= DLY; i++) begin
      xc_d[i] <= xc_d[i-1];
      xs_d[i] <= xs_d[i-1];
    end
  end

  // scaling, rounding, mean offset and saturation
  logic signed [31:0] trig [0:1];
  logic [30:0]        mag [0:1];
  logic [49:0]        p1 [0:1];
  logic [27:0]        m1_r [0:1];
  logic               neg1_r [0:1];
  logic [43:0]        m2_r [0:1];
  logic               neg2_r [0:1];
  logic [43:0]        rnd_sum [0:1];
  logic signed [25:0] val [0:1];
  logic signed [23:0] res [0:1];

  assign trig[0] = xc_d[DLY];
  assign trig[1] = xs_d[DLY];

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      mag[b] = trig[b][31] ? 31'(-trig[b]) : 31'(trig[b]);
      p1[b] = 50'(rad) * 50'(mag[b]);
      rnd_sum[b] = m2_r[b] + 44'h80_0000;
      val[b] = $signed({6'b0, rnd_sum[b][43:24]});
      if (neg2_r[b]) begin
        val[b] = -val[b];
      end
      val[b] = val[b] + 26'(mean_r);
      if (val[b] > 26'sd8388607) begin
        res[b] = 24'sd8388607;
      end else if (val[b] < -26'sd8388608) begin
        res[b] = -24'sd8388608;
      end else begin
        res[b] = 24'(val[b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 2; b++) begin
      m1_r[b]   <= p1[b][49:22];
      neg1_r[b] <= trig[b][31];
      m2_r[b]   <= 44'(m1_r[b]) * 44'(std_r);
      neg2_r[b] <= neg1_r[b];
    end
    out_data.first_normal  <= res[0];
    out_data.second_normal <= res[1];
  end

  assign out_valid = vld_r[OUT_STAGE];

  a_out_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, OUT_STAGE + 1))
    else $error("result strobe without a matching start transfer");

  a_trig_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[TRIG_STAGE] |-> (xc_d[0] <= 32'sd1073741824) && (xc_d[0] >= -32'sd1073741824)
                       && (xs_d[0] <= 32'sd1073741824) && (xs_d[0] >= -32'sd1073741824))
    else $error("trig value outside unit range");

  a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[R_STAGE] && rad == '0) |=> (m1_r[0] == '0) && (m1_r[1] == '0))
    else $error("zero radius gave a non-zero magnitude");

endmodule

// File: tb/tb_box_muller_gaussian_pair_unit.sv
// testbench for the box-muller gaussian pair unit with its scoreboard
`timescale 1ns / 1ps

module tb_box_muller_gaussian_pair_unit;
  import bmg_pkg::*;

  typedef longint unsigned u64_t;

  localparam int UBITS = 16;
  localparam int SETTLE = 60;
  localparam u64_t ONE_Q30 = 64'd1 << 30;
  localparam u64_t LN2X2 = 64'd744261118;
  localparam u64_t TWOPI = 64'd1686629713;

  class gaussian_scoreboard;
    out_item_t pairs_due[$];
    logic signed [15:0] mean_value = 16'sd0;
    logic [15:0] std_dev = 16'd256;
    int errors = 0;

    function void set_reg(cfg_reg_t idx, logic [15:0] val);
      if (idx == REG_MEAN_VALUE) begin
        mean_value = val;
      end else begin
        std_dev = val;
      end
    endfunction

    function u64_t neg_log2(u64_t u);
      u64_t m, f;
      int e;
      f = 0;
      e = 0;
      if (u == 0) return 0;
      for (int i = 0; i < 32; i++) if (u[i]) e = i;
      m = u << (31 - e);
      for (int i = 0; i < 28; i++) begin
        m = (m * m) >> 31;
        if (m >= (64'd1 << 32)) begin
          m = m >> 1;
          f = f | (64'd1 << (27 - i));
        end
      end
      return (u64_t'(UBITS) << 28) - ((u64_t'(e) << 28) + f);
    endfunction

    function u64_t root(u64_t x);
      u64_t res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function u64_t sine(u64_t t);
      u64_t t2, a, b, c;
      t2 = (t * t) >> 30;
      a = ONE_Q30 - t2 / 42;
      b = ONE_Q30 - ((t2 * a) >> 30) / 20;
      c = ONE_Q30 - ((t2 * b) >> 30) / 6;
      return (t * c) >> 30;
    endfunction

    function u64_t cosine(u64_t t);
      u64_t t2, a, b, c;
      t2 = (t * t) >> 30;
      a = ONE_Q30 - t2 / 56;
      b = ONE_Q30 - ((t2 * a) >> 30) / 30;
      c = ONE_Q30 - ((t2 * b) >> 30) / 12;
      return ONE_Q30 - ((t2 * c) >> 30) / 2;
    endfunction

    function logic [23:0] scaled(u64_t r, longint trig);
      u64_t mag;
      longint v;
      mag = (trig < 0) ? u64_t'(-trig) : u64_t'(trig);
      mag = ((r * mag) >> 22) * u64_t'(std_dev);
      mag = (mag + (64'd1 << 23)) >> 24;
      v = longint'(mag);
      if (trig < 0) v = -v;
      v = v + longint'(mean_value);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[23:0];
    endfunction

    function void note_input(in_item_t it);
      u64_t r, t, cm, sm;
      logic [31:0] p, d;
      quad_t q;
      logic dneg;
      longint cv, sv, xc, xs;
      out_item_t exp_pair;
      r = root(((neg_log2(u64_t'(it.uniform_radius)) * LN2X2) >> 27) << 2);
      p = {it.uniform_angle, 16'd0};
      q = quad_t'((p + 32'h2000_0000) >> 30);
      d = p - {q, 30'd0};
      dneg = d[31];
      if (dneg) d = 32'd0 - d;
      t = (u64_t'(d) * TWOPI) >> 30;
      cm = cosine(t);
      sm = sine(t);
      cv = longint'(cm);
      sv = dneg ? -longint'(sm) : longint'(sm);
      case (q)
        QUAD_0: begin xc = cv;  xs = sv;  end
        QUAD_1: begin xc = -sv; xs = cv;  end
        QUAD_2: begin xc = -cv; xs = -sv; end
        default: begin xc = sv; xs = -cv; end
      endcase
      exp_pair.first_normal = scaled(r, xc);
      exp_pair.second_normal = scaled(r, xs);
      pairs_due.push_back(exp_pair);
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      if (pairs_due.size() == 0) begin
        $error("unexpected result transfer %h", got);
        errors++;
        return;
      end
      want = pairs_due.pop_front();
      if (got.first_normal !== want.first_normal) begin
        $error("first_normal expected %0d actual %0d", want.first_normal, got.first_normal);
        errors++;
      end
      if (got.second_normal !== want.second_normal) begin
        $error("second_normal expected %0d actual %0d", want.second_normal,
               got.second_normal);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_MEAN_VALUE;
  logic [15:0] cfg_wdata = '0;

  gaussian_scoreboard sb = new();

  box_muller_gaussian_pair_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_data);
  end

  task automatic send_pair(logic [15:0] u1, logic [15:0] u2, int idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= '{uniform_radius: u1, uniform_angle: u2};
    do @(posedge clk); while (busy);
    sb.note_input('{uniform_radius: u1, uniform_angle: u2});
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pairs_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_radius();
    case ($urandom_range(3))
      0: return 16'($urandom_range(31));
      1: return 16'($urandom_range(65535, 65000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    if ($urandom_range(3) == 0) return 16'({$urandom_range(7), 13'd0} + $urandom_range(8) - 4);
    return 16'($urandom);
  endfunction

  initial begin
    logic [15:0] radii [6] = '{16'd0, 16'd1, 16'd2, 16'd32768, 16'd65535, 16'd12345};
    logic [15:0] angles [4] = '{16'd0, 16'd8192, 16'd16384, 16'd65535};
    logic signed [15:0] means [6] = '{16'sd0, -16'sd32768, 16'sd32767, 16'sd100,
                                      -16'sd5000, 16'sd0};
    logic [15:0] devs [6] = '{16'd0, 16'd65535, 16'd65535, 16'd256, 16'd1, 16'd40000};
    int idle_pct;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (radii[i]) send_pair(radii[i], angles[i % 4], 0);
    foreach (angles[j]) send_pair(16'd40000, angles[j] ^ 16'h0001, 0);
    send_pair(16'd3, 16'd24576, 0);
    send_pair(16'd65535, 16'd49152, 0);
    send_pair(16'd100, 16'd57344, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MEAN_VALUE, means[ph]);
      write_reg(REG_STD_DEV, devs[ph]);
      idle_pct = (ph < 2) ? 37 : (ph < 4) ? 45 : 0;
      repeat (80) send_pair(pick_radius(), pick_angle(), idle_pct);
      drain();
    end

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
design/bmg_pkg.sv
design/bmg_log_cell.sv
design/bmg_sqrt_cell.sv
design/bmg_horner_cell.sv
design/box_muller_gaussian_pair_unit.sv
tb/tb_box_muller_gaussian_pair_unit.sv
